/* rtl/keypad_clock_time_set_controller_defines.svh */
// Assertion macros for the keypad clock time-set controller.
`ifndef KEYPAD_CLOCK_TIME_SET_CONTROLLER_DEFINES_SVH
`define KEYPAD_CLOCK_TIME_SET_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kcts same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kcts next-cycle check failed");

`endif

/* rtl/kcts_pkg.sv */
// Shared types and constants for the keypad clock time-set controller.
`default_nettype none

package kcts_pkg;

    localparam int HOLD_TIMER_BITS = 16;
    localparam int CFG_W = 16;
    localparam int CMP_W = (HOLD_TIMER_BITS > CFG_W) ? HOLD_TIMER_BITS : CFG_W;

    localparam logic [CFG_W-1:0] HOLD_RESET = 16'd2000;

    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_P    = 4'd11;
    localparam logic [3:0] KEY_M    = 4'd12;
    localparam logic [3:0] KEY_STAR = 4'd13;
    localparam logic [3:0] KEY_HASH = 4'd14;
    localparam logic [3:0] KEY_D    = 4'd15;

    localparam logic [4:0] CHAR_BLANK = 5'd16;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SET    = 2'd1,
        MODE_ERROR  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        FLD_HOUR = 2'd0,
        FLD_MIN  = 2'd1,
        FLD_AMPM = 2'd2
    } t_field;

    // Field check results for the current two-character entry.
    typedef struct packed {
        logic       hour_ok;
        logic       min_ok;
        logic       ampm_ok;
        logic       is_pm;
        logic [6:0] value;
    } t_chk;

    // One result word.
    typedef struct packed {
        t_mode      mode;
        t_field     field;
        logic [4:0] first;
        logic [4:0] second;
        logic       time_set;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_result;

endpackage

`default_nettype wire

/* rtl/kcts_check.sv */
// Field checker: decodes the two-character entry into a value and validity flags.
`default_nettype none

module kcts_check (
    input  wire logic [4:0]   i_first,
    input  wire logic [4:0]   i_second,
    output kcts_pkg::t_chk    o_chk
);
    import kcts_pkg::*;

    logic       digits;
    logic [6:0] value;

    always_comb begin
        digits = (i_first < 5'd10) && (i_second < 5'd10);
        // tens * 10 as (tens << 3) + (tens << 1)
        value  = 7'({i_first[3:0], 3'b000}) + 7'({i_first[3:0], 1'b0})
               + 7'(i_second[3:0]);

        o_chk.value   = value;
        o_chk.hour_ok = digits && (value >= 7'd1) && (value <= 7'd12);
        o_chk.min_ok  = digits && (value <= 7'd59);
        o_chk.is_pm   = (i_first == {1'b0, KEY_P});
        o_chk.ampm_ok = ((i_first == {1'b0, KEY_A}) || (i_first == {1'b0, KEY_P}))
                     && (i_second == {1'b0, KEY_M});
    end

endmodule

`default_nettype wire

/* rtl/kcts_ctrl.sv */
// Mode/field state machine, entry registers and error hold timer.
`default_nettype none

module kcts_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic                       i_kind,
    input  wire logic [3:0]                 i_key_code,
    input  wire logic [kcts_pkg::CFG_W-1:0] i_hold,
    output kcts_pkg::t_result               o_next
);
    import kcts_pkg::*;

    t_mode      r_mode,      n_mode;
    t_field     r_field,     n_field;
    logic [4:0] r_first,     n_first;
    logic [4:0] r_second,    n_second;
    logic       r_slot,      n_slot;
    logic [4:0] r_pend_hour, n_pend_hour;
    logic [5:0] r_pend_min,  n_pend_min;
    logic [HOLD_TIMER_BITS-1:0] r_elapsed, n_elapsed;

    logic [HOLD_TIMER_BITS-1:0] elapsed_inc;
    logic                       elapsed_max;
    logic [4:0]                 pm_hour;
    t_chk                       chk;

    kcts_check u_check (
        .i_first  (r_first),
        .i_second (r_second),
        .o_chk    (chk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_field     <= FLD_HOUR;
            r_first     <= CHAR_BLANK;
            r_second    <= CHAR_BLANK;
            r_slot      <= 1'b0;
            r_pend_hour <= '0;
            r_pend_min  <= '0;
            r_elapsed   <= '0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_field     <= n_field;
            r_first     <= n_first;
            r_second    <= n_second;
            r_slot      <= n_slot;
            r_pend_hour <= n_pend_hour;
            r_pend_min  <= n_pend_min;
            r_elapsed   <= n_elapsed;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_field     = r_field;
        n_first     = r_first;
        n_second    = r_second;
        n_slot      = r_slot;
        n_pend_hour = r_pend_hour;
        n_pend_min  = r_pend_min;
        n_elapsed   = r_elapsed;

        o_next.time_set = 1'b0;
        o_next.hour     = '0;
        o_next.minute   = '0;

        // saturating hold counter
        elapsed_max = (r_elapsed == {HOLD_TIMER_BITS{1'b1}});
        elapsed_inc = elapsed_max ? r_elapsed : r_elapsed + HOLD_TIMER_BITS'(1);

        pm_hour = (chk.is_pm && (r_pend_hour != 5'd12)) ? r_pend_hour + 5'd12
                                                         : r_pend_hour;

        if (i_kind == KIND_TICK) begin
            if (r_mode == MODE_ERROR) begin
                if ((CMP_W'(elapsed_inc) >= CMP_W'(i_hold))
                        || (elapsed_inc == {HOLD_TIMER_BITS{1'b1}})) begin
                    n_mode    = MODE_SET;
                    n_slot    = 1'b0;
                    n_elapsed = '0;
                end else begin
                    n_elapsed = elapsed_inc;
                end
            end
        end else if (r_mode != MODE_ERROR) begin
            if (i_key_code == KEY_STAR) begin
                n_mode   = MODE_SET;
                n_field  = FLD_HOUR;
                n_slot   = 1'b0;
                n_first  = CHAR_BLANK;
                n_second = CHAR_BLANK;
            end else if (i_key_code == KEY_D) begin
                n_mode   = MODE_NORMAL;
                n_field  = FLD_HOUR;
                n_first  = CHAR_BLANK;
                n_second = CHAR_BLANK;
            end else if (r_mode == MODE_SET) begin
                if (i_key_code != KEY_HASH) begin
                    if (r_slot) begin
                        n_second = {1'b0, i_key_code};
                    end else begin
                        n_first = {1'b0, i_key_code};
                    end
                    n_slot = !r_slot;
                end else begin
                    n_first  = CHAR_BLANK;
                    n_second = CHAR_BLANK;
                    unique case (r_field)
                        FLD_HOUR: begin
                            if (chk.hour_ok) begin
                                n_pend_hour = chk.value[4:0];
                                n_field     = FLD_MIN;
                            end else begin
                                n_mode    = MODE_ERROR;
                                n_elapsed = '0;
                            end
                        end
                        FLD_MIN: begin
                            if (chk.min_ok) begin
                                n_pend_min = chk.value[5:0];
                                n_field    = FLD_AMPM;
                            end else begin
                                n_mode    = MODE_ERROR;
                                n_elapsed = '0;
                            end
                        end
                        default: begin
                            if (chk.ampm_ok) begin
                                n_pend_hour     = pm_hour;
                                o_next.time_set = 1'b1;
                                o_next.hour     = pm_hour;
                                o_next.minute   = r_pend_min;
                                n_mode          = MODE_NORMAL;
                                n_field         = FLD_HOUR;
                            end else begin
                                n_mode    = MODE_ERROR;
                                n_elapsed = '0;
                            end
                        end
                    endcase
                end
            end
        end

        o_next.mode   = n_mode;
        o_next.field  = n_field;
        o_next.first  = n_first;
        o_next.second = n_second;
    end

endmodule

`default_nettype wire

/* rtl/keypad_clock_time_set_controller.sv */
// Top level of the keypad clock time-set controller: input, result and config registers.
//
//  Channel | Direction | Handshake                | Word
//  --------+-----------+--------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_ready  | i_kind, i_key_code
//  out     | from blk  | o_out_valid / i_out_ready| mode, field, entry chars, time set
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_data (error hold in ms)
//
// One word per cycle sustained while the output does not stall. On the way to the result,
// the word lands in the input register, then one pass through the state update logic
// loads the result register and the controller state together (two register stages).
// Reset (i_rst_n low, synchronous) empties both registers and returns to normal mode,
// hour field, blank entry; the error hold reads 2000 ms until written.
// A stall on the output holds the result register and, through it, the input register.
`default_nettype none

`include "keypad_clock_time_set_controller_defines.svh"

module keypad_clock_time_set_controller (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input words
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_kind,
    input  wire logic [3:0]                 i_key_code,
    // result words
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [1:0]                      o_mode_now,
    output logic [1:0]                      o_field_now,
    output logic [4:0]                      o_entry_first,
    output logic [4:0]                      o_entry_second,
    output logic                            o_time_set,
    output logic [4:0]                      o_new_hour,
    output logic [5:0]                      o_new_minute,
    // configuration
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [kcts_pkg::CFG_W-1:0] i_cfg_data
);
    import kcts_pkg::*;

    logic             r_in_valid;
    logic             r_in_kind;
    logic [3:0]       r_in_key;
    logic             r_out_valid;
    t_result          r_out;
    logic [CFG_W-1:0] r_hold;

    logic    step;
    t_result next_res;

    // advance when the input register is full and the result register can take a word
    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_RESET;
        end else if (i_cfg_valid) begin
            r_hold <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_kind <= i_kind;
            r_in_key  <= i_key_code;
        end
    end

    kcts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_kind     (r_in_kind),
        .i_key_code (r_in_key),
        .i_hold     (r_hold),
        .o_next     (next_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= next_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode_now     = r_out.mode;
    assign o_field_now    = r_out.field;
    assign o_entry_first  = r_out.first;
    assign o_entry_second = r_out.second;
    assign o_time_set     = r_out.time_set;
    assign o_new_hour     = r_out.hour;
    assign o_new_minute   = r_out.minute;

    // a commit always lands back in normal mode at the hour field
    `KCTS_ASSERT_NOW(a_commit_mode, i_clk, i_rst_n, r_out_valid && r_out.time_set, (r_out.mode == MODE_NORMAL) && (r_out.field == FLD_HOUR))
    // committed time reads zero unless a commit happened
    `KCTS_ASSERT_NOW(a_time_zero, i_clk, i_rst_n, r_out_valid && !r_out.time_set, (r_out.hour == 5'd0) && (r_out.minute == 6'd0))
    // error mode is only entered by a check that blanks the entry, and keys are ignored there
    `KCTS_ASSERT_NOW(a_error_blank, i_clk, i_rst_n, r_out_valid && (r_out.mode == MODE_ERROR), (r_out.first == CHAR_BLANK) && (r_out.second == CHAR_BLANK))
    // a held input word is never dropped
    `KCTS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !step, r_in_valid)

endmodule

`default_nettype wire

/* bench/keypad_time_set_checker.sv */
// Result checker for the keypad clock time-set controller: predicts each word and compares.
`timescale 1ns / 1ps

module keypad_time_set_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_ready,
    input  wire logic                       i_kind,
    input  wire logic [3:0]                 i_key_code,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic [1:0]                 i_mode_now,
    input  wire logic [1:0]                 i_field_now,
    input  wire logic [4:0]                 i_entry_first,
    input  wire logic [4:0]                 i_entry_second,
    input  wire logic                       i_time_set,
    input  wire logic [4:0]                 i_new_hour,
    input  wire logic [5:0]                 i_new_minute,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [kcts_pkg::CFG_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_words_in_flight
);
    import kcts_pkg::*;

    localparam logic [HOLD_TIMER_BITS-1:0] HOLD_MAX = '1;

    // shadow of the controller state
    t_mode                      mode;
    t_field                     field;
    logic [4:0]                 chars [2];
    logic                       slot;
    logic [4:0]                 pend_hour;
    logic [5:0]                 pend_minute;
    logic [HOLD_TIMER_BITS-1:0] err_ticks;
    logic [CFG_W-1:0]           hold_ms;

    t_result                    awaited_words [$];

    initial begin
        o_fail_count      = 0;
        o_words_in_flight = 0;
    end

    function automatic void enter_error();
        mode      = MODE_ERROR;
        err_ticks = '0;
    endfunction

    // Applies one input word to the shadow state and returns the status it leaves.
    function automatic t_result step_time_setter(input logic kind, input logic [3:0] key);
        t_result    r;
        logic       digits;
        int         num;
        logic [4:0] hr;
        r = '0;
        if (kind == KIND_TICK) begin
            if (mode == MODE_ERROR) begin
                if (err_ticks != HOLD_MAX)
                    err_ticks++;
                if (err_ticks >= hold_ms || err_ticks == HOLD_MAX) begin
                    mode      = MODE_SET;
                    slot      = 1'b0;
                    err_ticks = '0;
                end
            end
        end else if (mode != MODE_ERROR) begin
            if (key == KEY_STAR) begin
                mode     = MODE_SET;
                field    = FLD_HOUR;
                slot     = 1'b0;
                chars[0] = CHAR_BLANK;
                chars[1] = CHAR_BLANK;
            end else if (key == KEY_D) begin
                mode     = MODE_NORMAL;
                field    = FLD_HOUR;
                chars[0] = CHAR_BLANK;
                chars[1] = CHAR_BLANK;
            end else if (mode == MODE_SET) begin
                if (key != KEY_HASH) begin
                    chars[slot] = {1'b0, key};
                    slot        = ~slot;
                end else begin
                    digits = (chars[0] <= 5'd9) && (chars[1] <= 5'd9);
                    num    = int'(chars[0]) * 10 + int'(chars[1]);
                    case (field)
                        FLD_HOUR: begin
                            if (!digits || num < 1 || num > 12) begin
                                enter_error();
                            end else begin
                                pend_hour = 5'(num);
                                field     = FLD_MIN;
                            end
                        end
                        FLD_MIN: begin
                            if (!digits || num > 59) begin
                                enter_error();
                            end else begin
                                pend_minute = 6'(num);
                                field       = FLD_AMPM;
                            end
                        end
                        default: begin
                            if (!((chars[0] == {1'b0, KEY_A} || chars[0] == {1'b0, KEY_P})
                                  && chars[1] == {1'b0, KEY_M})) begin
                                enter_error();
                            end else begin
                                hr = pend_hour;
                                // PM adds twelve, except that 12 PM is noon
                                if (chars[0] == {1'b0, KEY_P} && hr != 5'd12)
                                    hr = hr + 5'd12;
                                pend_hour  = hr;
                                r.time_set = 1'b1;
                                r.hour     = hr;
                                r.minute   = pend_minute;
                                mode       = MODE_NORMAL;
                                field      = FLD_HOUR;
                            end
                        end
                    endcase
                    chars[0] = CHAR_BLANK;
                    chars[1] = CHAR_BLANK;
                end
            end
        end
        r.mode   = mode;
        r.field  = field;
        r.first  = chars[0];
        r.second = chars[1];
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            mode        = MODE_NORMAL;
            field       = FLD_HOUR;
            chars[0]    = CHAR_BLANK;
            chars[1]    = CHAR_BLANK;
            slot        = 1'b0;
            pend_hour   = '0;
            pend_minute = '0;
            err_ticks   = '0;
            hold_ms     = HOLD_RESET;
            awaited_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                hold_ms = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (awaited_words.size() == 0) begin
                    $error("result word with nothing awaited");
                    o_fail_count++;
                end else begin
                    want = awaited_words.pop_front();
                    check_field("mode_now", want.mode, i_mode_now);
                    check_field("field_now", want.field, i_field_now);
                    check_field("entry_first", want.first, i_entry_first);
                    check_field("entry_second", want.second, i_entry_second);
                    check_field("time_set", want.time_set, i_time_set);
                    check_field("new_hour", want.hour, i_new_hour);
                    check_field("new_minute", want.minute, i_new_minute);
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_words.push_back(step_time_setter(i_kind, i_key_code));
        end
        o_words_in_flight = awaited_words.size();
    end

endmodule

/* bench/tb_keypad_clock_time_set_controller.sv */
// Testbench top for the keypad clock time-set controller: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_keypad_clock_time_set_controller;
    import kcts_pkg::*;

    localparam int CYCLE_LIMIT    = 40_000;
    localparam int SQUEEZE_CYCLES = 400;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    logic             i_kind      = KIND_KEY;
    logic [3:0]       i_key_code  = 4'd0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_mode_now;
    logic [1:0]       o_field_now;
    logic [4:0]       o_entry_first;
    logic [4:0]       o_entry_second;
    logic             o_time_set;
    logic [4:0]       o_new_hour;
    logic [5:0]       o_new_minute;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    int               fail_count;
    int               words_in_flight;
    int               words_sent   = 0;
    int               cycle_count  = 0;
    int               squeeze_left = 0;
    logic             calm         = 1'b0;   // no idling on either side while set
    logic             squeeze_req  = 1'b0;   // asks the receiver for one long hold-off
    logic             squeeze_done = 1'b0;
    logic [CFG_W-1:0] hold_ms      = HOLD_RESET;   // error hold the block currently uses

    // Opening key words: ignored keys in normal mode, 12:00 AM (hour stays 12),
    // 11:59 PM (23:59), then '#' on a blank hour, which enters error mode,
    // followed by '*', 'D' and a digit that error mode must ignore.
    logic [3:0] opening_keys [27] = '{
        4'd7, KEY_D, KEY_STAR, 4'd1, 4'd2, KEY_HASH, 4'd0, 4'd0, KEY_HASH,
        KEY_A, KEY_M, KEY_HASH, KEY_STAR, 4'd1, 4'd1, KEY_HASH, 4'd5, 4'd9,
        KEY_HASH, KEY_P, KEY_M, KEY_HASH, KEY_STAR, KEY_HASH, KEY_STAR, KEY_D, 4'd3
    };

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    keypad_clock_time_set_controller dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_key_code     (i_key_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mode_now     (o_mode_now),
        .o_field_now    (o_field_now),
        .o_entry_first  (o_entry_first),
        .o_entry_second (o_entry_second),
        .o_time_set     (o_time_set),
        .o_new_hour     (o_new_hour),
        .o_new_minute   (o_new_minute),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    keypad_time_set_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_key_code        (i_key_code),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_mode_now        (o_mode_now),
        .i_field_now       (o_field_now),
        .i_entry_first     (o_entry_first),
        .i_entry_second    (o_entry_second),
        .i_time_set        (o_time_set),
        .i_new_hour        (o_new_hour),
        .i_new_minute      (o_new_minute),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_words_in_flight (words_in_flight)
    );

    // Result side: ready drops ~7% of cycles at random, never while calm.
    // One long hold-off on request lets the pipeline fill so the input stalls.
    always @(negedge i_clk) begin
        if (squeeze_left > 0) begin
            i_out_ready <= 1'b0;
            squeeze_left = squeeze_left - 1;
        end else if (squeeze_req && !squeeze_done) begin
            i_out_ready <= 1'b0;
            squeeze_left = SQUEEZE_CYCLES - 1;
            squeeze_done = 1'b1;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    // Offers one input word and returns at the falling edge after it is taken.
    // Valid stays high on return, so back-to-back words need no extra edge;
    // anything that is not another word must lower it first.
    task automatic send_word(input logic kind, input logic [3:0] key);
        while (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key_code <= key;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic press(input logic [3:0] key);
        send_word(KIND_KEY, key);
    endtask

    // Tick words carry a random key code, which the block must ignore.
    task automatic tick_burst(input int count);
        repeat (count)
            send_word(KIND_TICK, 4'($urandom_range(15)));
    endtask

    // Mostly the intended key, now and then any key at all.
    function automatic logic [3:0] pick(input logic [3:0] good);
        return ($urandom_range(99) < 95) ? good : 4'($urandom_range(15));
    endfunction

    // One field entry closed by '#'. Occasionally broken: a stray leading key
    // makes the write slot wrap, a dropped key leaves a blank, or 'D' aborts.
    task automatic enter_pair(input logic [3:0] c0, input logic [3:0] c1);
        int shape;
        shape = $urandom_range(99);
        if ($urandom_range(99) < 10)
            send_word(KIND_TICK, 4'($urandom_range(15)));
        if (shape < 4)
            press(4'($urandom_range(15)));
        press(pick(c0));
        if (shape < 4 || shape >= 8)
            press(pick(c1));
        if (shape >= 8 && shape < 11)
            press(KEY_D);
        press(KEY_HASH);
    endtask

    // One attempt at setting the time, or a short burst of noise. Ends with a
    // random run of ticks so an error hold usually, not always, runs out.
    task automatic try_time_entry();
        int hour;
        int minute;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 6))
                send_word(1'($urandom_range(1)), 4'($urandom_range(15)));
            return;
        end
        if ($urandom_range(99) < 90)
            press(KEY_STAR);
        hour   = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(0, 19);
        minute = ($urandom_range(99) < 90) ? $urandom_range(0, 59) : $urandom_range(60, 99);
        enter_pair(4'(hour / 10), 4'(hour % 10));
        enter_pair(4'(minute / 10), 4'(minute % 10));
        enter_pair($urandom_range(1) ? KEY_P : KEY_A, KEY_M);
        tick_burst($urandom_range(0, int'(hold_ms) + 2));
    endtask

    task automatic run_attempts(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target)
            try_time_entry();
    endtask

    // Error hold changes only with nothing in flight.
    task automatic write_hold(input logic [CFG_W-1:0] ms);
        i_in_valid <= 1'b0;
        while (words_in_flight != 0)
            @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ms;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        hold_ms = ms;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, default hold of 2000 ms. A tick in normal mode does nothing.
        send_word(KIND_TICK, 4'd0);
        foreach (opening_keys[i])
            press(opening_keys[i]);
        // Ticks well short of the default hold: still in error, keys still ignored.
        tick_burst(40);
        press(4'd4);
        // Hold lowered mid-error to one above the count so far: the next tick ends it.
        write_hold(16'd41);
        send_word(KIND_TICK, 4'd15);
        // Back in set mode at the hour field with the slot at zero.
        press(4'd0);
        press(4'd6);
        press(KEY_HASH);

        // Zero hold: the first tick ends error mode.
        write_hold('0);
        run_attempts(200);

        write_hold(16'd1);
        run_attempts(150);

        write_hold(CFG_W'($urandom_range(2, 12)));
        run_attempts(100);
        calm = 1'b1;
        run_attempts(150);
        calm = 1'b0;
        squeeze_req = 1'b1;
        run_attempts(250);

        // Largest hold: a few ticks leave error mode in place; a shorter hold written
        // mid-error is already passed, so the next tick ends it.
        tick_burst(int'(hold_ms) + 1);
        write_hold('1);
        press(KEY_STAR);
        press(4'd9);
        press(4'd9);
        press(KEY_HASH);
        tick_burst(5);
        press(KEY_STAR);
        write_hold(16'd3);
        send_word(KIND_TICK, 4'd0);

        write_hold(CFG_W'($urandom_range(3, 9)));
        run_attempts(350);

        i_in_valid <= 1'b0;
        while (words_in_flight != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && words_in_flight == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/kcts_pkg.sv
rtl/kcts_check.sv
rtl/kcts_ctrl.sv
rtl/keypad_clock_time_set_controller.sv
bench/keypad_time_set_checker.sv
bench/tb_keypad_clock_time_set_controller.sv
